// ----- src/minimum_image_wrap_macros.svh -----
// Assertion macros for the minimum-image wrap block.
// MIM_ASSERT expects clk and arst_n in the scope of the module that uses it, MIM_ASSERT_ALWAYS only clk.
`ifndef MINIMUM_IMAGE_WRAP_MACROS_SVH
`define MINIMUM_IMAGE_WRAP_MACROS_SVH

`ifndef SYNTHESIS
// checked out of reset only
`define MIM_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// checked at every edge, reset included
`define MIM_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MIM_ASSERT(lbl, prop, msg)
`define MIM_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ----- src/mim_pkg.sv -----
package mim_pkg;

	// coordinate and cell matrix fraction bits
	localparam int COORD_FRAC = 16;
	localparam int BOX_FRAC   = 8;

	localparam int NUM_AXES  = 3;
	localparam int CFG_IDX_W = 3;
	localparam int PDIM_W    = 2;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PERIODIC_DIMS = 3'd0,
		REG_DIAGONAL_BOX  = 3'd1,
		REG_INV_ROW_X     = 3'd2,
		REG_INV_ROW_Y     = 3'd3,
		REG_INV_ROW_Z     = 3'd4,
		REG_BOX_ROW_X     = 3'd5,
		REG_BOX_ROW_Y     = 3'd6,
		REG_BOX_ROW_Z     = 3'd7
	} cfg_reg_t;

	// matrix entry enables (row, column) and per-axis wrap enables
	typedef struct packed {
		logic [NUM_AXES-1:0][NUM_AXES-1:0] use_e;
		logic [NUM_AXES-1:0]               wrap;
	} mim_ctl_t;

endpackage

// ----- src/mim_fwd.sv -----
// Forward half: displacement times inverse cell matrix, then nearest-integer removal.
// Stage 1 registers the nine products, stage 2 the reduced fractional coordinates.
module mim_fwd #(
	parameter int CW  = 32,
	parameter int MEW = 20
) (
	input  logic                           clk,
	input  logic                           en,
	input  mim_pkg::mim_ctl_t              ctl,
	input  logic [CW-1:0]                  d [mim_pkg::NUM_AXES],
	input  logic [3*MEW-1:0]               inv_row [mim_pkg::NUM_AXES],
	output logic [mim_pkg::COORD_FRAC+MEW-2:0] r_s2 [mim_pkg::NUM_AXES]
);

	localparam int SFRAC    = mim_pkg::COORD_FRAC + MEW - 2;
	localparam int P_W      = CW + MEW;
	localparam int S_W      = P_W + 2;
	// fractional sums wrap at 64 bits
	localparam int SIGN_BIT = (S_W > 64) ? 63 : S_W - 1;

	logic signed [P_W-1:0] prod    [mim_pkg::NUM_AXES][mim_pkg::NUM_AXES];
	logic signed [P_W-1:0] prod_s1 [mim_pkg::NUM_AXES][mim_pkg::NUM_AXES];
	logic signed [S_W-1:0] sum     [mim_pkg::NUM_AXES];
	logic [mim_pkg::NUM_AXES-1:0] up;

	// nine products d[j] * inv[i][j]
	always_comb begin
		for (int i = 0; i < mim_pkg::NUM_AXES; i++) begin
			for (int j = 0; j < mim_pkg::NUM_AXES; j++) begin
				prod[i][j] = P_W'(signed'(d[j])) * P_W'(signed'(inv_row[i][j*MEW +: MEW]));
			end
		end
	end

	// stage 1: masked products
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < mim_pkg::NUM_AXES; i++) begin
				for (int j = 0; j < mim_pkg::NUM_AXES; j++) begin
					prod_s1[i][j] <= ctl.use_e[i][j] ? prod[i][j] : '0;
				end
			end
		end
	end

	// row sums and rounding decision, ties away from zero
	always_comb begin
		for (int i = 0; i < mim_pkg::NUM_AXES; i++) begin
			sum[i] = S_W'(prod_s1[i][0]) + S_W'(prod_s1[i][1]) + S_W'(prod_s1[i][2]);
			if (sum[i][SIGN_BIT]) begin
				up[i] = sum[i][SFRAC-1] && (|sum[i][SFRAC-2:0]);
			end else begin
				up[i] = sum[i][SFRAC-1];
			end
		end
	end

	// stage 2: reduced coordinate; subtracting one just sets the sign bit
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < mim_pkg::NUM_AXES; i++) begin
				r_s2[i] <= {up[i], sum[i][SFRAC-1:0]};
			end
		end
	end

endmodule

// ----- src/mim_back.sv -----
// Back half: reduced coordinates times cell matrix, rounding and saturation.
// Stage 3 registers the products, stage 4 the rounded sums; saturation is combinational.
module mim_back #(
	parameter int CW  = 32,
	parameter int MEW = 20
) (
	input  logic                               clk,
	input  logic                               en,
	input  mim_pkg::mim_ctl_t                  ctl,
	input  logic [mim_pkg::COORD_FRAC+MEW-2:0] r_s2 [mim_pkg::NUM_AXES],
	input  logic [3*MEW-1:0]                   box_row [mim_pkg::NUM_AXES],
	output logic [CW-1:0]                      sat [mim_pkg::NUM_AXES]
);

	localparam int SFRAC     = mim_pkg::COORD_FRAC + MEW - 2;
	localparam int R_W       = SFRAC + 1;
	localparam int P_W       = R_W + MEW;
	localparam int A_W       = P_W + 3;
	localparam int OUT_SHIFT = SFRAC + mim_pkg::BOX_FRAC - mim_pkg::COORD_FRAC;
	localparam int SH_W      = A_W - OUT_SHIFT;
	localparam int C_W       = ((SH_W > CW) ? SH_W : CW) + 1;

	localparam logic signed [A_W-1:0] RND = A_W'(1) << (OUT_SHIFT - 1);
	localparam logic signed [C_W-1:0] HI  = {{(C_W-CW+1){1'b0}}, {(CW-1){1'b1}}};
	localparam logic signed [C_W-1:0] LO  = {{(C_W-CW+1){1'b1}}, {(CW-1){1'b0}}};

	logic signed [P_W-1:0] prod    [mim_pkg::NUM_AXES][mim_pkg::NUM_AXES];
	logic signed [P_W-1:0] prod_s3 [mim_pkg::NUM_AXES][mim_pkg::NUM_AXES];
	logic signed [A_W-1:0] acc     [mim_pkg::NUM_AXES];
	logic signed [A_W-1:0] acc_s4  [mim_pkg::NUM_AXES];
	logic signed [C_W-1:0] shx     [mim_pkg::NUM_AXES];

	// nine products r[j] * box[i][j]
	always_comb begin
		for (int i = 0; i < mim_pkg::NUM_AXES; i++) begin
			for (int j = 0; j < mim_pkg::NUM_AXES; j++) begin
				prod[i][j] = P_W'(signed'(r_s2[j])) * P_W'(signed'(box_row[i][j*MEW +: MEW]));
			end
		end
	end

	// stage 3: masked products
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < mim_pkg::NUM_AXES; i++) begin
				for (int j = 0; j < mim_pkg::NUM_AXES; j++) begin
					prod_s3[i][j] <= ctl.use_e[i][j] ? prod[i][j] : '0;
				end
			end
		end
	end

	// row sum plus half an output lsb
	always_comb begin
		for (int i = 0; i < mim_pkg::NUM_AXES; i++) begin
			acc[i] = A_W'(prod_s3[i][0]) + A_W'(prod_s3[i][1]) + A_W'(prod_s3[i][2]) + RND;
		end
	end

	// stage 4
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < mim_pkg::NUM_AXES; i++) begin
				acc_s4[i] <= acc[i];
			end
		end
	end

	// floor shift and saturate
	always_comb begin
		for (int i = 0; i < mim_pkg::NUM_AXES; i++) begin
			shx[i] = C_W'(acc_s4[i] >>> OUT_SHIFT);
			if (shx[i] > HI) begin
				sat[i] = HI[CW-1:0];
			end else if (shx[i] < LO) begin
				sat[i] = LO[CW-1:0];
			end else begin
				sat[i] = shx[i][CW-1:0];
			end
		end
	end

endmodule

// ----- src/minimum_image_wrap.sv -----
// Minimum-image wrap of a displacement in a triclinic periodic cell.
// Each input beat passes stages 1 to 5 in order; stage 5 is the output register.
// Throughput: one beat per cycle; the five pipeline stages advance together and
// hold while a finished beat waits on m_axis_tready.
// Reset: arst_n clears all stage valids and loads periodic_dims = 3, diagonal_box = 0,
// and all matrix rows to zero.
`include "minimum_image_wrap_macros.svh"

module minimum_image_wrap #(
	parameter int COORD_WIDTH        = 32,
	parameter int MATRIX_ENTRY_WIDTH = 20
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// slave side
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// disp_x, disp_y, disp_z, zero padding
	input  logic [((3*COORD_WIDTH+7)/8)*8-1:0]  s_axis_tdata,
	input  logic                                s_axis_tlast,   // last_in
	// master side
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// wrapped_x, wrapped_y, wrapped_z, zero padding
	output logic [((3*COORD_WIDTH+7)/8)*8-1:0]  m_axis_tdata,
	output logic                                m_axis_tlast,   // last_out
	// configuration writes
	input  logic                                cfg_we,
	input  logic [mim_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [3*MATRIX_ENTRY_WIDTH-1:0]     cfg_data
);

	localparam int CW     = COORD_WIDTH;
	localparam int MEW    = MATRIX_ENTRY_WIDTH;
	localparam int DATA_W = ((3*CW+7)/8)*8;
	localparam int ROW_W  = 3*MEW;
	localparam int SFRAC  = mim_pkg::COORD_FRAC + MEW - 2;

	logic [mim_pkg::PDIM_W-1:0] pdims_q;
	logic                       diag_q;
	logic [ROW_W-1:0]           inv_row_q [mim_pkg::NUM_AXES];
	logic [ROW_W-1:0]           box_row_q [mim_pkg::NUM_AXES];

	mim_pkg::mim_ctl_t ctl;
	logic              diag;
	logic              en;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic last_s1, last_s2, last_s3, last_s4, last_s5;
	logic [CW-1:0] din         [mim_pkg::NUM_AXES];
	logic [CW-1:0] d_s1        [mim_pkg::NUM_AXES];
	logic [CW-1:0] d_s2        [mim_pkg::NUM_AXES];
	logic [CW-1:0] d_s3        [mim_pkg::NUM_AXES];
	logic [CW-1:0] d_s4        [mim_pkg::NUM_AXES];
	logic [CW-1:0] wrapped_s5  [mim_pkg::NUM_AXES];
	logic [SFRAC:0] r_s2       [mim_pkg::NUM_AXES];
	logic [CW-1:0] sat         [mim_pkg::NUM_AXES];

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pdims_q <= 2'd3;
			diag_q  <= 1'b0;
			for (int i = 0; i < mim_pkg::NUM_AXES; i++) begin
				inv_row_q[i] <= '0;
				box_row_q[i] <= '0;
			end
		end else if (cfg_we) begin
			case (mim_pkg::cfg_reg_t'(cfg_index))
				mim_pkg::REG_PERIODIC_DIMS: pdims_q      <= cfg_data[mim_pkg::PDIM_W-1:0];
				mim_pkg::REG_DIAGONAL_BOX:  diag_q       <= cfg_data[0];
				mim_pkg::REG_INV_ROW_X:     inv_row_q[0] <= cfg_data;
				mim_pkg::REG_INV_ROW_Y:     inv_row_q[1] <= cfg_data;
				mim_pkg::REG_INV_ROW_Z:     inv_row_q[2] <= cfg_data;
				mim_pkg::REG_BOX_ROW_X:     box_row_q[0] <= cfg_data;
				mim_pkg::REG_BOX_ROW_Y:     box_row_q[1] <= cfg_data;
				mim_pkg::REG_BOX_ROW_Z:     box_row_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	// matrix entry and wrap enables from the dimension settings
	always_comb begin
		diag = (pdims_q == 2'd3) && diag_q;
		ctl  = '0;
		for (int i = 0; i < mim_pkg::NUM_AXES; i++) begin
			ctl.wrap[i] = 2'(i) < pdims_q;
			for (int j = 0; j < mim_pkg::NUM_AXES; j++) begin
				ctl.use_e[i][j] = (2'(i) < pdims_q) && (2'(j) < pdims_q) && (!diag || (i == j));
			end
		end
	end

	// whole pipe advances unless the output beat is stalled
	assign en            = !vld_s5 || m_axis_tready;
	assign s_axis_tready = en;

	always_comb begin
		for (int i = 0; i < mim_pkg::NUM_AXES; i++) begin
			din[i] = s_axis_tdata[i*CW +: CW];
		end
	end

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s1 <= s_axis_tvalid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	// pass-through coordinates, last flag and output register
	always_ff @(posedge clk) begin
		if (en) begin
			last_s1 <= s_axis_tlast;
			last_s2 <= last_s1;
			last_s3 <= last_s2;
			last_s4 <= last_s3;
			last_s5 <= last_s4;
			for (int i = 0; i < mim_pkg::NUM_AXES; i++) begin
				d_s1[i]       <= din[i];
				d_s2[i]       <= d_s1[i];
				d_s3[i]       <= d_s2[i];
				d_s4[i]       <= d_s3[i];
				wrapped_s5[i] <= ctl.wrap[i] ? sat[i] : d_s4[i];
			end
		end
	end

	mim_fwd #(
		.CW  (CW),
		.MEW (MEW)
	) u_fwd (
		.clk     (clk),
		.en      (en),
		.ctl     (ctl),
		.d       (din),
		.inv_row (inv_row_q),
		.r_s2    (r_s2)
	);

	mim_back #(
		.CW  (CW),
		.MEW (MEW)
	) u_back (
		.clk     (clk),
		.en      (en),
		.ctl     (ctl),
		.r_s2    (r_s2),
		.box_row (box_row_q),
		.sat     (sat)
	);

	assign m_axis_tvalid = vld_s5;
	assign m_axis_tlast  = last_s5;
	assign m_axis_tdata  = DATA_W'({wrapped_s5[2], wrapped_s5[1], wrapped_s5[0]});

	// checks
	`MIM_ASSERT(a_accept_fills_s1, s_axis_tvalid && s_axis_tready |=> vld_s1, "accepted beat lost at stage 1")
	`MIM_ASSERT(a_stall_holds_pipe, !en |=> $stable({vld_s1, vld_s2, vld_s3, vld_s4, vld_s5}), "pipe moved during stall")
	`MIM_ASSERT(a_reduce_range, vld_s2 |-> (r_s2[0][SFRAC] == r_s2[0][SFRAC-1]) || (r_s2[0][SFRAC-2:0] == '0), "reduced x outside half cell")
	`MIM_ASSERT(a_x_passthrough, en && vld_s4 && !ctl.wrap[0] |=> wrapped_s5[0] == $past(d_s4[0]), "unwrapped x altered")
	`MIM_ASSERT_ALWAYS(a_reset_empties, !arst_n |=> !m_axis_tvalid, "output valid after reset")

endmodule

// ----- tb/minimum_image_wrap_tb.sv -----
`timescale 1ns / 1ps

module minimum_image_wrap_tb;

	localparam int COORD_W     = 32;
	localparam int ENTRY_W     = 20;
	localparam int ROW_W       = 3 * ENTRY_W;
	localparam int DATA_W      = ((3 * COORD_W + 7) / 8) * 8;
	localparam int FRAC_S      = 34;   // 16 coordinate + 18 inverse fraction bits
	localparam int OUT_SH      = 26;   // 34 + 8 - 16
	localparam int DRAIN_SLACK = 8;    // pipeline is 5 deep
	localparam int HOLD_CYCLES = 300;
	localparam int STALL_LIMIT = 2000;
	localparam int Q16_ONE     = 65536;

	typedef struct packed {
		logic signed [COORD_W-1:0] z;
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] x;
		logic                      last;
	} disp_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                          s_axis_tvalid = 1'b0;
	logic                          s_axis_tready;
	logic [DATA_W-1:0]             s_axis_tdata = '0;    // disp_x, disp_y, disp_z
	logic                          s_axis_tlast = 1'b0;  // last_in
	logic                          m_axis_tvalid;
	logic                          m_axis_tready = 1'b0;
	logic [DATA_W-1:0]             m_axis_tdata;         // wrapped_x, wrapped_y, wrapped_z
	logic                          m_axis_tlast;         // last_out
	logic                          cfg_we = 1'b0;
	logic [mim_pkg::CFG_IDX_W-1:0] cfg_index = mim_pkg::REG_PERIODIC_DIMS;
	logic [ROW_W-1:0]              cfg_data = '0;

	// shadow of the cell registers, reset values
	logic [1:0]       cell_dims = 2'd3;
	logic             cell_diag = 1'b0;
	logic [ROW_W-1:0] inv_rows [3] = '{default: '0};
	logic [ROW_W-1:0] box_rows [3] = '{default: '0};

	disp_t wrapped_q [$];
	int    failures   = 0;
	int    beats_in   = 0;
	int    beats_out  = 0;
	int    cells_used = 0;
	int    idle_cnt   = 0;
	int    hold_left  = 0;
	bit    idle_on    = 1'b1;

	minimum_image_wrap u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always #1 clk = ~clk;

	// ---------------------------------------------------------------
	// prediction
	// ---------------------------------------------------------------

	function automatic longint row_coef(logic [ROW_W-1:0] row, int k);
		logic signed [ENTRY_W-1:0] e;
		e = row[k*ENTRY_W +: ENTRY_W];
		return longint'(e);
	endfunction

	// fractional coordinate minus nearest integer, ties away from zero
	function automatic longint frac_reduce(longint s);
		longint one, half, low;
		one  = longint'(1) << FRAC_S;
		half = one >>> 1;
		low  = s & (one - 1);
		if ((s >= 0) ? (low >= half) : (low > half))
			return low - one;
		return low;
	endfunction

	function automatic disp_t wrap_predict(disp_t din);
		longint d [3];
		longint r [3];
		longint acc;
		logic signed [COORD_W-1:0] o [3];
		int n;
		bit dg;
		disp_t res;
		d[0] = din.x;
		d[1] = din.y;
		d[2] = din.z;
		n  = cell_dims;
		dg = (n == 3) && cell_diag;
		for (int i = 0; i < 3; i++)
			o[i] = d[i][COORD_W-1:0];
		// to fractional coordinates, top-left n x n block only
		for (int i = 0; i < n; i++) begin
			acc = 0;
			for (int j = 0; j < n; j++)
				if (!dg || i == j)
					acc += d[j] * row_coef(inv_rows[i], j);
			r[i] = frac_reduce(acc);
		end
		// back to cartesian, round half up, saturate
		for (int i = 0; i < n; i++) begin
			acc = longint'(1) << (OUT_SH - 1);
			for (int j = 0; j < n; j++)
				if (!dg || i == j)
					acc += r[j] * row_coef(box_rows[i], j);
			acc = acc >>> OUT_SH;
			if (acc > 64'sd2147483647)
				acc = 64'sd2147483647;
			else if (acc < -64'sd2147483648)
				acc = -64'sd2147483648;
			o[i] = acc[COORD_W-1:0];
		end
		res.x    = o[0];
		res.y    = o[1];
		res.z    = o[2];
		res.last = din.last;
		return res;
	endfunction

	// ---------------------------------------------------------------
	// checking
	// ---------------------------------------------------------------

	task automatic check_field(string tag, logic [COORD_W-1:0] want, logic [COORD_W-1:0] got);
		if (want !== got) begin
			failures++;
			$display("%0t: %s mismatch, expected %0d actual %0d",
				$time, tag, $signed(want), $signed(got));
		end
	endtask

	// results first, then new inputs, so a beat never meets its own expectation
	always @(posedge clk) begin
		disp_t want;
		disp_t din;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				beats_out++;
				if (wrapped_q.size() == 0) begin
					failures++;
					$display("%0t: result beat with nothing expected, actual x=%0d y=%0d z=%0d",
						$time, $signed(m_axis_tdata[31:0]), $signed(m_axis_tdata[63:32]),
						$signed(m_axis_tdata[95:64]));
				end else begin
					want = wrapped_q.pop_front();
					check_field("wrapped_x", want.x, m_axis_tdata[31:0]);
					check_field("wrapped_y", want.y, m_axis_tdata[63:32]);
					check_field("wrapped_z", want.z, m_axis_tdata[95:64]);
					check_field("last_out", {31'd0, want.last}, {31'd0, m_axis_tlast});
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				din.x    = s_axis_tdata[31:0];
				din.y    = s_axis_tdata[63:32];
				din.z    = s_axis_tdata[95:64];
				din.last = s_axis_tlast;
				wrapped_q.push_back(wrap_predict(din));
				beats_in++;
			end
		end
	end

	// receiver: random idling, plus a long hold-off on request
	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= !(idle_on && $urandom_range(99) < 10);
		end
	end

	// watchdog on cycles with no beat on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				idle_cnt = 0;
			else
				idle_cnt++;
			if (idle_cnt >= STALL_LIMIT) begin
				$display("%0t: no beat accepted for %0d cycles, %0d results outstanding",
					$time, idle_cnt, wrapped_q.size());
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	// ---------------------------------------------------------------
	// stimulus helpers; all entered right after a rising edge
	// ---------------------------------------------------------------

	task automatic send_disp(disp_t b);
		while (idle_on && $urandom_range(99) < 10) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {b.z, b.y, b.x};
		s_axis_tlast  <= b.last;
		do
			@(posedge clk);
		while (!s_axis_tready);
	endtask

	function automatic disp_t mk_disp(int x, int y, int z, bit last);
		disp_t b;
		b.x    = x;
		b.y    = y;
		b.z    = z;
		b.last = last;
		return b;
	endfunction

	// stop offering and wait for every outstanding result
	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		// let the monitor record a beat accepted at the edge just passed
		@(posedge clk);
		while (wrapped_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_SLACK) @(posedge clk);
	endtask

	task automatic put_reg(mim_pkg::cfg_reg_t idx, logic [ROW_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
	endtask

	task automatic load_config(logic [1:0] pd, logic dg,
		logic [ROW_W-1:0] ix, logic [ROW_W-1:0] iy, logic [ROW_W-1:0] iz,
		logic [ROW_W-1:0] bx, logic [ROW_W-1:0] by, logic [ROW_W-1:0] bz);
		wait_drained();
		put_reg(mim_pkg::REG_PERIODIC_DIMS, ROW_W'(pd));
		put_reg(mim_pkg::REG_DIAGONAL_BOX, ROW_W'(dg));
		put_reg(mim_pkg::REG_INV_ROW_X, ix);
		put_reg(mim_pkg::REG_INV_ROW_Y, iy);
		put_reg(mim_pkg::REG_INV_ROW_Z, iz);
		put_reg(mim_pkg::REG_BOX_ROW_X, bx);
		put_reg(mim_pkg::REG_BOX_ROW_Y, by);
		put_reg(mim_pkg::REG_BOX_ROW_Z, bz);
		cfg_we <= 1'b0;
		cell_dims   = pd;
		cell_diag   = dg;
		inv_rows[0] = ix;
		inv_rows[1] = iy;
		inv_rows[2] = iz;
		box_rows[0] = bx;
		box_rows[1] = by;
		box_rows[2] = bz;
		cells_used++;
	endtask

	// bits [19:0] multiply x, [39:20] y, [59:40] z
	function automatic logic [ROW_W-1:0] pack_row(int ex, int ey, int ez);
		return {ENTRY_W'(ez), ENTRY_W'(ey), ENTRY_W'(ex)};
	endfunction

	function automatic int to_fixed(real v, real scale);
		return $rtoi(v * scale + ((v >= 0.0) ? 0.5 : -0.5));
	endfunction

	task automatic load_cubic(logic [1:0] pd, logic dg, real len);
		int ei, eb;
		ei = to_fixed(1.0 / len, 262144.0);
		eb = to_fixed(len, 256.0);
		load_config(pd, dg, pack_row(ei, 0, 0), pack_row(0, ei, 0), pack_row(0, 0, ei),
			pack_row(eb, 0, 0), pack_row(0, eb, 0), pack_row(0, 0, eb));
	endtask

	task automatic load_uniform(logic [1:0] pd, logic dg, int e);
		load_config(pd, dg, pack_row(e, e, e), pack_row(e, e, e), pack_row(e, e, e),
			pack_row(e, e, e), pack_row(e, e, e), pack_row(e, e, e));
	endtask

	// upper triangular cell with its exact inverse, then quantized
	task automatic load_triclinic(logic [1:0] pd, logic dg);
		real a, b, c, bxy, cxz, cyz;
		real h [3][3];
		real g [3][3];
		int  hq [3][3];
		int  gq [3][3];
		a   = 4.0 + $urandom_range(5600) / 100.0;
		b   = 4.0 + $urandom_range(5600) / 100.0;
		c   = 4.0 + $urandom_range(5600) / 100.0;
		bxy = ($urandom_range(1000) / 1000.0 - 0.5) * a;
		cxz = ($urandom_range(1000) / 1000.0 - 0.5) * a;
		cyz = ($urandom_range(1000) / 1000.0 - 0.5) * b;
		h = '{'{a, bxy, cxz}, '{0.0, b, cyz}, '{0.0, 0.0, c}};
		g = '{'{1.0 / a, -bxy / (a * b), (bxy * cyz - cxz * b) / (a * b * c)},
			'{0.0, 1.0 / b, -cyz / (b * c)},
			'{0.0, 0.0, 1.0 / c}};
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++) begin
				hq[i][j] = to_fixed(h[i][j], 256.0);
				gq[i][j] = to_fixed(g[i][j], 262144.0);
			end
		load_config(pd, dg,
			pack_row(gq[0][0], gq[0][1], gq[0][2]),
			pack_row(gq[1][0], gq[1][1], gq[1][2]),
			pack_row(gq[2][0], gq[2][1], gq[2][2]),
			pack_row(hq[0][0], hq[0][1], hq[0][2]),
			pack_row(hq[1][0], hq[1][1], hq[1][2]),
			pack_row(hq[2][0], hq[2][1], hq[2][2]));
	endtask

	task automatic load_random_matrices(logic [1:0] pd, logic dg);
		logic [ROW_W-1:0] rw [6];
		for (int k = 0; k < 6; k++)
			rw[k] = ROW_W'({$urandom, $urandom});
		load_config(pd, dg, rw[0], rw[1], rw[2], rw[3], rw[4], rw[5]);
	endtask

	// mostly displacements of a few cells, some full range and extremes
	function automatic int rand_coord();
		int pick;
		pick = $urandom_range(9);
		if (pick < 7)
			return int'($urandom_range(16777215)) - 8388608;
		if (pick < 9)
			return int'($urandom);
		case ($urandom_range(3))
			0: return 32'sh7FFFFFFF;
			1: return 32'sh80000000;
			2: return -1;
			default: return 0;
		endcase
	endfunction

	// ---------------------------------------------------------------
	// tests
	// ---------------------------------------------------------------

	// zero matrices after reset with three periodic dims
	task automatic test_reset_defaults();
		send_disp(mk_disp(Q16_ONE, -5 * Q16_ONE / 2, 7 * Q16_ONE, 1'b0));
		send_disp(mk_disp(32'sh7FFFFFFF, 32'sh80000000, 0, 1'b1));
	endtask

	// no periodic dims: every component unchanged
	task automatic test_passthrough();
		load_random_matrices(2'd0, 1'b1);
		send_disp(mk_disp(32'sh7FFFFFFF, 32'sh80000000, -1, 1'b1));
		send_disp(mk_disp(0, 1, 32'sh80000000, 1'b0));
		send_disp(mk_disp(32'sh80000000, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 1'b1));
	endtask

	// cell of length 2 puts odd displacements exactly on half-cell ties
	task automatic test_ties();
		load_cubic(2'd3, 1'b0, 2.0);
		send_disp(mk_disp(Q16_ONE, -Q16_ONE, 3 * Q16_ONE, 1'b0));
		send_disp(mk_disp(-3 * Q16_ONE, 5 * Q16_ONE, -5 * Q16_ONE, 1'b1));
		send_disp(mk_disp(Q16_ONE - 1, Q16_ONE + 1, -Q16_ONE - 1, 1'b0));
		send_disp(mk_disp(-Q16_ONE + 1, 0, 2 * Q16_ONE, 1'b1));
	endtask

	// one and two periodic dims; diagonal flag set but ignored
	task automatic test_partial_dims();
		load_cubic(2'd1, 1'b1, 20.0);
		send_disp(mk_disp(25 * Q16_ONE, 25 * Q16_ONE, 25 * Q16_ONE, 1'b0));
		send_disp(mk_disp(-11 * Q16_ONE, -31 * Q16_ONE, 47 * Q16_ONE, 1'b1));
		load_triclinic(2'd2, 1'b1);
		send_disp(mk_disp(25 * Q16_ONE, 25 * Q16_ONE, 25 * Q16_ONE, 1'b0));
		send_disp(mk_disp(-11 * Q16_ONE, -31 * Q16_ONE, 47 * Q16_ONE, 1'b1));
	endtask

	// full triclinic matrix against the diagonal-only path
	task automatic test_diagonal_box();
		load_triclinic(2'd3, 1'b1);
		send_disp(mk_disp(37 * Q16_ONE, -19 * Q16_ONE, 53 * Q16_ONE, 1'b0));
		send_disp(mk_disp(rand_coord(), rand_coord(), rand_coord(), 1'b1));
		load_triclinic(2'd3, 1'b0);
		send_disp(mk_disp(37 * Q16_ONE, -19 * Q16_ONE, 53 * Q16_ONE, 1'b0));
		send_disp(mk_disp(rand_coord(), rand_coord(), rand_coord(), 1'b1));
	endtask

	// largest and most negative entries with extreme displacements
	task automatic test_extreme_matrices();
		load_uniform(2'd3, 1'b0, 32'h7FFFF);
		send_disp(mk_disp(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 1'b0));
		send_disp(mk_disp(32'sh80000000, 32'sh80000000, 32'sh80000000, 1'b1));
		load_uniform(2'd3, 1'b0, -32'h80000);
		send_disp(mk_disp(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 1'b0));
		send_disp(mk_disp(32'sh80000000, 32'sh80000000, 32'sh80000000, 1'b1));
	endtask

	// receiver holds off while beats keep coming, so the pipe fills and stalls
	task automatic test_backpressure();
		load_triclinic(2'd3, 1'b0);
		hold_left = HOLD_CYCLES;
		for (int k = 0; k < 40; k++)
			send_disp(mk_disp(rand_coord(), rand_coord(), rand_coord(),
				1'($urandom_range(1))));
	endtask

	// random cells and displacements; one phase without idling, one with a
	// mid-stream pause until all results are back
	task automatic test_random();
		for (int ph = 0; ph < 6; ph++) begin
			if (ph == 4)
				load_random_matrices(2'($urandom_range(3)), 1'($urandom_range(1)));
			else if (ph == 0)
				load_triclinic(2'd3, 1'($urandom_range(1)));
			else
				load_triclinic(2'($urandom_range(3)), 1'($urandom_range(1)));
			idle_on = (ph != 2);
			for (int k = 0; k < 80; k++) begin
				if (ph == 3 && k == 40)
					wait_drained();
				send_disp(mk_disp(rand_coord(), rand_coord(), rand_coord(),
					1'($urandom_range(1))));
			end
		end
		idle_on = 1'b1;
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_passthrough();
		test_ties();
		test_partial_dims();
		test_diagonal_box();
		test_extreme_matrices();
		test_backpressure();
		test_random();
		wait_drained();
		$display("covered %0d displacements over %0d cell settings: 0 to 3 periodic dims,",
			beats_in, cells_used);
		$display("diagonal and full matrices, exact ties, extreme entries, long output stall");
		if (failures == 0 && wrapped_q.size() == 0 && beats_out == beats_in)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

// ----- filelist.f -----
+incdir+src
src/mim_pkg.sv
src/mim_fwd.sv
src/mim_back.sv
src/minimum_image_wrap.sv
tb/minimum_image_wrap_tb.sv
